FILE: src/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console cell writer package
// Shared types and constants for the character-cell console store.
// ----------------------------------------------------------------------------
package tccw_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_PUT_WR,
      ST_RD_ISSUE,
      ST_RD_CAP,
      ST_SCROLL_SET,
      ST_SWEEP_RD,
      ST_SWEEP_WR,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      JOB_PUT,
      JOB_READ,
      JOB_SCROLL
   } job_type;

   typedef enum logic [2:0] {
      ACT_PUT    = 3'd0,
      ACT_LOCATE = 3'd1,
      ACT_MOVE   = 3'd2,
      ACT_SCROLL = 3'd3,
      ACT_CLEAR  = 3'd4,
      ACT_READ   = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_WIDTH     = 2'd1,
      STAT_OFFSCREEN = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0]  bg;
      logic [7:0]  fg;
      logic [15:0] code;
   } cell_type;

   localparam logic [1:0]  CFG_FG      = 2'd0;
   localparam logic [1:0]  CFG_BG      = 2'd1;
   localparam logic [1:0]  CFG_WRAP    = 2'd2;
   localparam logic [1:0]  CFG_UNICODE = 2'd3;

   localparam logic [15:0] CODE_NL  = 16'd10;
   localparam logic [15:0] CODE_CR  = 16'd13;
   localparam logic [15:0] CODE_TAB = 16'd9;

   localparam logic [7:0]  TAB_STEP  = 8'd4;
   localparam logic [7:0]  BLANK_FG  = 8'd255;
   localparam logic [7:0]  RESET_FG  = 8'd255;
   localparam logic [7:0]  RESET_BG  = 8'd0;

endpackage

FILE: src/tccw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tccw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1152
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// Text console cell writer
// Character-cell console store with cursor, wrap, scroll, clear and read-back.
// ----------------------------------------------------------------------------
// Cell addresses for puts and reads, and the source start of a scroll, come
// from one shared multiply-add unit with a registered result; the sweeps
// step source and destination counters. The store is one RAM with a single
// read port, so a scroll copies each cell with a read and then a write, and
// blanks one vacated cell per cycle. After reset a clearing pass runs with
// req_tready low; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
   parameter int COLUMNS = 48,
   parameter int ROWS    = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_code[15:0], coord_x[23:16], coord_y[31:24], scroll_rows[36:32],
   // clear_color[44:37], zero[47:45]
   input  logic [47:0] req_tdata,
   // action[2:0], char_wide[3]
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cursor_col[7:0], cursor_row[15:8], read_code[31:16], read_fg[39:32],
   // read_bg[47:40]
   output logic [47:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W  = $clog2(ROWS + 1);

   localparam logic [CNT_W-1:0] CELLS_V = CNT_W'(CELLS);
   localparam logic [CNT_W-1:0] LAST_V  = CNT_W'(CELLS - 1);
   localparam logic [CNT_W-1:0] COLS_V  = CNT_W'(COLUMNS);
   localparam logic [7:0]       COLS_B  = 8'(COLUMNS);
   localparam logic [7:0]       ROWS_B  = 8'(ROWS);

   function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? 8'hFF : s[7:0];
   endfunction

   tccw_pkg::state_type  state_ff, state_in;
   tccw_pkg::job_type    job_ff, job_in;
   tccw_pkg::action_type act_ff, act_in;

   logic [7:0]        fg_ff, fg_in, bg_ff, bg_in;
   logic              wrap_ff, wrap_in, uni_ff, uni_in;
   logic [7:0]        col_ff, col_in, line_ff, line_in;
   logic              init_ff, init_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  src_ff, src_in, dst_ff, dst_in;
   logic [7:0]        fill_bg_ff, fill_bg_in;

   logic [15:0]       code_ff, code_in;
   logic              wide_ff, wide_in;
   logic signed [7:0] x_ff, x_in, y_ff, y_in;
   logic [4:0]        nrows_ff, nrows_in;
   logic [7:0]        ccol_ff, ccol_in;
   logic [1:0]        status_ff, status_in;
   logic [15:0]       rd_code_ff, rd_code_in;
   logic [7:0]        rd_fg_ff, rd_fg_in, rd_bg_ff, rd_bg_in;
   logic              scroll_pend_ff, scroll_pend_in;
   logic [ROW_W-1:0]  op_row_ff, op_row_in;
   logic [COL_W-1:0]  op_col_ff, op_col_in;
   logic [CNT_W-1:0]  unit_ff, unit_in;
   logic [47:0]       rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_user_ff, rsp_user_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   tccw_pkg::cell_type ram_wdata, ram_rdata;

   logic [7:0]        p_col, p_line;
   logic [1:0]        p_status;
   logic              p_write, p_scroll, p_skip;
   logic signed [9:0] mv_cx, mv_cy;
   logic              rd_inside;

   tccw_ram #(
      .WIDTH ($bits(tccw_pkg::cell_type)),
      .DEPTH (CELLS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Shared multiply-add unit: row * COLUMNS + column.
   assign unit_in = CNT_W'(op_row_ff) * COLS_V + CNT_W'(op_col_ff);

   always_comb begin
      p_col    = col_ff;
      p_line   = line_ff;
      p_status = tccw_pkg::STAT_OK;
      p_write  = 1'b0;
      p_scroll = 1'b0;
      p_skip   = 1'b0;
      case (code_ff)
         tccw_pkg::CODE_NL: begin
            p_col  = 8'h00;
            p_line = sat_add(line_ff, 8'd1);
         end
         tccw_pkg::CODE_CR: begin
            p_col = 8'h00;
         end
         tccw_pkg::CODE_TAB: begin
            p_col = sat_add(col_ff, tccw_pkg::TAB_STEP);
         end
         default: begin
            if (wide_ff != uni_ff) begin
               p_status = tccw_pkg::STAT_WIDTH;
               p_skip   = 1'b1;
            end else begin
               if (col_ff < COLS_B && line_ff < ROWS_B) begin
                  p_write = 1'b1;
               end else begin
                  p_status = tccw_pkg::STAT_OFFSCREEN;
               end
               p_col = sat_add(col_ff, 8'd1);
            end
         end
      endcase
      if (!p_skip && wrap_ff && p_col >= COLS_B) begin
         p_col  = 8'h00;
         p_line = sat_add(p_line, 8'd1);
      end
      if (!p_skip && wrap_ff && p_line >= ROWS_B) begin
         p_line   = 8'(ROWS - 1);
         p_scroll = 1'b1;
      end
   end

   always_comb begin
      mv_cx = $signed({2'b00, col_ff}) + $signed({{2{x_ff[7]}}, x_ff});
      mv_cy = $signed({2'b00, line_ff}) + $signed({{2{y_ff[7]}}, y_ff});
      if (mv_cx < 10'sd0) begin
         mv_cx = 10'sd0;
         mv_cy = mv_cy - 10'sd1;
      end else if (mv_cx >= $signed(10'(COLUMNS))) begin
         mv_cx = 10'sd0;
         mv_cy = mv_cy + 10'sd1;
      end
      if (mv_cy < 10'sd0) begin
         mv_cy = 10'sd0;
      end else if (mv_cy >= $signed(10'(ROWS))) begin
         mv_cy = $signed(10'(ROWS - 1));
      end
   end

   assign rd_inside = !x_ff[7] && !y_ff[7] && ({1'b0, x_ff[6:0]} < COLS_B)
                      && ({1'b0, y_ff[6:0]} < ROWS_B);

   always_comb begin
      state_in       = state_ff;
      job_in         = job_ff;
      act_in         = act_ff;
      fg_in          = fg_ff;
      bg_in          = bg_ff;
      wrap_in        = wrap_ff;
      uni_in         = uni_ff;
      col_in         = col_ff;
      line_in        = line_ff;
      init_in        = init_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      src_in         = src_ff;
      dst_in         = dst_ff;
      fill_bg_in     = fill_bg_ff;
      code_in        = code_ff;
      wide_in        = wide_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      nrows_in       = nrows_ff;
      ccol_in        = ccol_ff;
      status_in      = status_ff;
      rd_code_in     = rd_code_ff;
      rd_fg_in       = rd_fg_ff;
      rd_bg_in       = rd_bg_ff;
      scroll_pend_in = scroll_pend_ff;
      op_row_in      = op_row_ff;
      op_col_in      = op_col_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      req_tready     = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = '0;
      ram_wdata      = '0;
      ram_raddr      = '0;

      if (csr_we) begin
         case (csr_index)
            tccw_pkg::CFG_FG:      fg_in   = csr_wdata;
            tccw_pkg::CFG_BG:      bg_in   = csr_wdata;
            tccw_pkg::CFG_WRAP:    wrap_in = csr_wdata[0];
            tccw_pkg::CFG_UNICODE: uni_in  = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         tccw_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               act_in   = tccw_pkg::action_type'(req_tuser[2:0]);
               wide_in  = req_tuser[3];
               code_in  = req_tdata[15:0];
               x_in     = req_tdata[23:16];
               y_in     = req_tdata[31:24];
               nrows_in = req_tdata[36:32];
               ccol_in  = req_tdata[44:37];
               state_in = tccw_pkg::ST_EXEC;
            end
         end
         tccw_pkg::ST_EXEC: begin
            status_in  = tccw_pkg::STAT_OK;
            rd_code_in = 16'h0000;
            rd_fg_in   = 8'h00;
            rd_bg_in   = 8'h00;
            state_in   = tccw_pkg::ST_DONE;
            case (act_ff)
               tccw_pkg::ACT_PUT: begin
                  col_in         = p_col;
                  line_in        = p_line;
                  status_in      = p_status;
                  scroll_pend_in = p_scroll;
                  if (p_write) begin
                     op_row_in = ROW_W'(line_ff);
                     op_col_in = COL_W'(col_ff);
                     job_in    = tccw_pkg::JOB_PUT;
                     state_in  = tccw_pkg::ST_MUL;
                  end else if (p_scroll) begin
                     op_row_in = ROW_W'(1);
                     op_col_in = '0;
                     job_in    = tccw_pkg::JOB_SCROLL;
                     state_in  = tccw_pkg::ST_MUL;
                  end
               end
               tccw_pkg::ACT_LOCATE: begin
                  col_in  = x_ff[7] ? 8'h00 : x_ff;
                  line_in = y_ff[7] ? 8'h00 : y_ff;
               end
               tccw_pkg::ACT_MOVE: begin
                  col_in  = mv_cx[7:0];
                  line_in = mv_cy[7:0];
               end
               tccw_pkg::ACT_SCROLL: begin
                  if (nrows_ff != 5'd0) begin
                     op_row_in = ({2'b00, nrows_ff} >= 7'(ROWS)) ? ROW_W'(ROWS)
                                                                 : ROW_W'(nrows_ff);
                     op_col_in = '0;
                     job_in    = tccw_pkg::JOB_SCROLL;
                     state_in  = tccw_pkg::ST_MUL;
                  end
               end
               tccw_pkg::ACT_CLEAR: begin
                  src_in     = CELLS_V;
                  dst_in     = '0;
                  fill_bg_in = ccol_ff;
                  state_in   = tccw_pkg::ST_SWEEP_RD;
               end
               tccw_pkg::ACT_READ: begin
                  if (rd_inside) begin
                     op_row_in = ROW_W'(y_ff[6:0]);
                     op_col_in = COL_W'(x_ff[6:0]);
                     job_in    = tccw_pkg::JOB_READ;
                     state_in  = tccw_pkg::ST_MUL;
                  end else begin
                     status_in = tccw_pkg::STAT_OFFSCREEN;
                  end
               end
               default: ;
            endcase
         end
         tccw_pkg::ST_MUL: begin
            case (job_ff)
               tccw_pkg::JOB_PUT:    state_in = tccw_pkg::ST_PUT_WR;
               tccw_pkg::JOB_READ:   state_in = tccw_pkg::ST_RD_ISSUE;
               tccw_pkg::JOB_SCROLL: state_in = tccw_pkg::ST_SCROLL_SET;
               default:              state_in = tccw_pkg::ST_DONE;
            endcase
         end
         tccw_pkg::ST_PUT_WR: begin
            ram_we         = 1'b1;
            ram_waddr      = unit_ff[ADDR_W-1:0];
            ram_wdata.code = wide_ff ? code_ff : {8'h00, code_ff[7:0]};
            ram_wdata.fg   = fg_ff;
            ram_wdata.bg   = bg_ff;
            if (scroll_pend_ff) begin
               op_row_in = ROW_W'(1);
               op_col_in = '0;
               job_in    = tccw_pkg::JOB_SCROLL;
               state_in  = tccw_pkg::ST_MUL;
            end else begin
               state_in = tccw_pkg::ST_DONE;
            end
         end
         tccw_pkg::ST_RD_ISSUE: begin
            ram_raddr = unit_ff[ADDR_W-1:0];
            state_in  = tccw_pkg::ST_RD_CAP;
         end
         tccw_pkg::ST_RD_CAP: begin
            rd_code_in = ram_rdata.code;
            rd_fg_in   = ram_rdata.fg;
            rd_bg_in   = ram_rdata.bg;
            state_in   = tccw_pkg::ST_DONE;
         end
         tccw_pkg::ST_SCROLL_SET: begin
            src_in     = unit_ff;
            dst_in     = '0;
            fill_bg_in = tccw_pkg::RESET_BG;
            state_in   = tccw_pkg::ST_SWEEP_RD;
         end
         tccw_pkg::ST_SWEEP_RD: begin
            if (src_ff < CELLS_V) begin
               ram_raddr = src_ff[ADDR_W-1:0];
               state_in  = tccw_pkg::ST_SWEEP_WR;
            end else begin
               ram_we         = 1'b1;
               ram_waddr      = dst_ff[ADDR_W-1:0];
               ram_wdata.code = 16'h0000;
               ram_wdata.fg   = tccw_pkg::BLANK_FG;
               ram_wdata.bg   = fill_bg_ff;
               dst_in         = dst_ff + CNT_W'(1);
               if (dst_ff == LAST_V) begin
                  init_in  = 1'b0;
                  state_in = init_ff ? tccw_pkg::ST_IDLE : tccw_pkg::ST_DONE;
               end
            end
         end
         tccw_pkg::ST_SWEEP_WR: begin
            ram_we    = 1'b1;
            ram_waddr = dst_ff[ADDR_W-1:0];
            ram_wdata = ram_rdata;
            dst_in    = dst_ff + CNT_W'(1);
            src_in    = src_ff + CNT_W'(1);
            if (dst_ff == LAST_V) begin
               init_in  = 1'b0;
               state_in = init_ff ? tccw_pkg::ST_IDLE : tccw_pkg::ST_DONE;
            end else begin
               state_in = tccw_pkg::ST_SWEEP_RD;
            end
         end
         tccw_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {rd_bg_ff, rd_fg_ff, rd_code_ff, line_ff, col_ff};
               rsp_user_in  = status_ff;
               state_in     = tccw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tccw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tccw_pkg::ST_SWEEP_RD;
         init_ff      <= 1'b1;
         src_ff       <= CELLS_V;
         dst_ff       <= '0;
         fill_bg_ff   <= tccw_pkg::RESET_BG;
         fg_ff        <= tccw_pkg::RESET_FG;
         bg_ff        <= tccw_pkg::RESET_BG;
         wrap_ff      <= 1'b1;
         uni_ff       <= 1'b0;
         col_ff       <= 8'h00;
         line_ff      <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         src_ff       <= src_in;
         dst_ff       <= dst_in;
         fill_bg_ff   <= fill_bg_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         wrap_ff      <= wrap_in;
         uni_ff       <= uni_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff         <= job_in;
      act_ff         <= act_in;
      code_ff        <= code_in;
      wide_ff        <= wide_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      nrows_ff       <= nrows_in;
      ccol_ff        <= ccol_in;
      status_ff      <= status_in;
      rd_code_ff     <= rd_code_in;
      rd_fg_ff       <= rd_fg_in;
      rd_bg_ff       <= rd_bg_in;
      scroll_pend_ff <= scroll_pend_in;
      op_row_ff      <= op_row_in;
      op_col_ff      <= op_col_in;
      unit_ff        <= unit_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tccw_pkg::ST_IDLE) |-> !ram_we)
      else $error("Cell store written while idle.");

   a_sweep_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tccw_pkg::ST_SWEEP_RD || state_ff == tccw_pkg::ST_SWEEP_WR)
      |-> (src_ff >= dst_ff))
      else $error("Sweep source address fell behind the destination.");

   a_cursor_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tccw_pkg::ST_SWEEP_WR) |=> ($stable(col_ff) && $stable(line_ff)))
      else $error("Cursor changed during a store sweep.");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the text console cell writer
// A short table of requests covers reset contents, field extremes and the
// error cases, and is followed by random request streams under changing
// colors, wrap and unicode settings. An untimed model of the cell grid and
// cursor predicts each beat that the table does not give; all are checked in order.
// ----------------------------------------------------------------------------
module tb;

   localparam int GRID_COLS   = 48;
   localparam int GRID_ROWS   = 24;
   localparam int GRID_CELLS  = GRID_COLS * GRID_ROWS;
   localparam int SEGMENTS    = 17;
   localparam int SAT_SEG     = 13;
   localparam int CYCLE_LIMIT = 30000000;

   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   localparam int STYLE_MIXED   = 0;
   localparam int STYLE_COL_RUN = 1;
   localparam int STYLE_ROW_RUN = 2;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] code;
      logic        wide;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [4:0]  nrows;
      logic [7:0]  ccol;
   } console_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [15:0] code;
      logic [7:0]  fg;
      logic [7:0]  bg;
   } console_rsp_type;

   typedef struct packed {
      console_req_type req;
      logic            typed;
      console_rsp_type want;
   } directed_row_type;

   localparam console_rsp_type NO_RSP = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   tccw_pkg::cell_type shadow_cells [GRID_CELLS];
   int                 cur_col;
   int                 cur_row;
   logic [7:0]         cfg_fg;
   logic [7:0]         cfg_bg;
   logic               cfg_wrap;
   logic               cfg_unicode;
   console_rsp_type    awaited_reports [$];

   int send_idle = 0;
   int recv_idle = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int action_count [8];
   int width_errors = 0;
   int offscreen_count = 0;
   int settings_used = 0;

   directed_row_type directed_rows [25];

   text_console_cell_writer #(
      .COLUMNS(GRID_COLS),
      .ROWS   (GRID_ROWS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int bump(int v, int d);
      return (v + d > 255) ? 255 : v + d;
   endfunction

   function automatic tccw_pkg::cell_type blank_cell(logic [7:0] bg);
      tccw_pkg::cell_type c;
      c.code = '0;
      c.fg   = tccw_pkg::BLANK_FG;
      c.bg   = bg;
      return c;
   endfunction

   function automatic void note_failure(string msg);
      if (fail_count < 10) begin
         $display("%s", msg);
      end
      fail_count++;
   endfunction

   function automatic console_req_type req_of(logic [2:0] a, logic [15:0] c, logic w,
                                              int x, int y, int n, int cc);
      console_req_type r;
      r.action = a;
      r.code   = c;
      r.wide   = w;
      r.x      = 8'(x);
      r.y      = 8'(y);
      r.nrows  = 5'(n);
      r.ccol   = 8'(cc);
      return r;
   endfunction

   task automatic scroll_shadow(int n);
      int lim;
      lim = (n > GRID_ROWS) ? GRID_ROWS : n;
      for (int r = 0; r + lim < GRID_ROWS; r++) begin
         for (int c = 0; c < GRID_COLS; c++) begin
            shadow_cells[r * GRID_COLS + c] = shadow_cells[(r + lim) * GRID_COLS + c];
         end
      end
      for (int i = (GRID_ROWS - lim) * GRID_COLS; i < GRID_CELLS; i++) begin
         shadow_cells[i] = blank_cell(8'h00);
      end
   endtask

   task automatic predict_console_action(input console_req_type r,
                                         output console_rsp_type o);
      int                 sx;
      int                 sy;
      int                 cx;
      int                 cy;
      logic [1:0]         st;
      tccw_pkg::cell_type c;
      sx = int'($signed(r.x));
      sy = int'($signed(r.y));
      st = tccw_pkg::STAT_OK;
      c  = '0;
      case (r.action)
         tccw_pkg::ACT_PUT: begin
            if (r.code == tccw_pkg::CODE_NL) begin
               cur_col = 0;
               cur_row = bump(cur_row, 1);
            end else if (r.code == tccw_pkg::CODE_CR) begin
               cur_col = 0;
            end else if (r.code == tccw_pkg::CODE_TAB) begin
               cur_col = bump(cur_col, int'(tccw_pkg::TAB_STEP));
            end else if (r.wide != cfg_unicode) begin
               st = tccw_pkg::STAT_WIDTH;
            end else begin
               if (cur_col < GRID_COLS && cur_row < GRID_ROWS) begin
                  shadow_cells[cur_row * GRID_COLS + cur_col].code =
                     r.wide ? r.code : {8'h00, r.code[7:0]};
                  shadow_cells[cur_row * GRID_COLS + cur_col].fg = cfg_fg;
                  shadow_cells[cur_row * GRID_COLS + cur_col].bg = cfg_bg;
               end else begin
                  st = tccw_pkg::STAT_OFFSCREEN;
               end
               cur_col = bump(cur_col, 1);
            end
            if (st != tccw_pkg::STAT_WIDTH) begin
               if (cfg_wrap && cur_col >= GRID_COLS) begin
                  cur_col = 0;
                  cur_row = bump(cur_row, 1);
               end
               if (cfg_wrap && cur_row >= GRID_ROWS) begin
                  cur_row = GRID_ROWS - 1;
                  scroll_shadow(1);
               end
            end
         end
         tccw_pkg::ACT_LOCATE: begin
            cur_col = (sx < 0) ? 0 : sx;
            cur_row = (sy < 0) ? 0 : sy;
         end
         tccw_pkg::ACT_MOVE: begin
            cx = cur_col + sx;
            cy = cur_row + sy;
            if (cx < 0) begin
               cx = 0;
               cy--;
            end
            if (cx >= GRID_COLS) begin
               cx = 0;
               cy++;
            end
            if (cy < 0) cy = 0;
            if (cy >= GRID_ROWS) cy = GRID_ROWS - 1;
            cur_col = cx;
            cur_row = cy;
         end
         tccw_pkg::ACT_SCROLL: begin
            scroll_shadow(int'(r.nrows));
         end
         tccw_pkg::ACT_CLEAR: begin
            for (int i = 0; i < GRID_CELLS; i++) begin
               shadow_cells[i] = blank_cell(r.ccol);
            end
         end
         tccw_pkg::ACT_READ: begin
            if (sx >= 0 && sx < GRID_COLS && sy >= 0 && sy < GRID_ROWS) begin
               c = shadow_cells[sy * GRID_COLS + sx];
            end else begin
               st = tccw_pkg::STAT_OFFSCREEN;
            end
         end
         default: begin
         end
      endcase
      o.status = st;
      o.col    = 8'(cur_col);
      o.row    = 8'(cur_row);
      o.code   = c.code;
      o.fg     = c.fg;
      o.bg     = c.bg;
   endtask

   function automatic console_req_type random_req(int style);
      console_req_type r;
      logic [63:0]     bits;
      int              p;
      bits = {$urandom, $urandom};
      r = bits[$bits(console_req_type)-1:0];
      p = $urandom_range(99);
      if (style == STYLE_COL_RUN) begin
         r.action = tccw_pkg::ACT_PUT;
         r.wide   = cfg_unicode;
         r.code   = (p < 50) ? tccw_pkg::CODE_TAB : 16'h0041 + 16'(p);
      end else if (style == STYLE_ROW_RUN) begin
         r.action = tccw_pkg::ACT_PUT;
         r.wide   = cfg_unicode;
         if (p < 80) begin
            r.code = tccw_pkg::CODE_NL;
         end else if (p < 90) begin
            r.code = 16'h0041 + 16'(p);
         end else begin
            r.action = tccw_pkg::ACT_READ;
            r.x = 8'($urandom_range(GRID_COLS - 1));
            r.y = 8'($urandom_range(GRID_ROWS - 1));
         end
      end else if (p < 45) begin
         r.action = tccw_pkg::ACT_PUT;
         p = $urandom_range(99);
         if (p < 8) begin
            r.code = tccw_pkg::CODE_NL;
         end else if (p < 12) begin
            r.code = tccw_pkg::CODE_CR;
         end else if (p < 16) begin
            r.code = tccw_pkg::CODE_TAB;
         end else begin
            r.wide = ($urandom_range(99) < 85) ? cfg_unicode : !cfg_unicode;
            if (!r.wide && p < 80) r.code[15:8] = '0;
         end
      end else if (p < 57) begin
         r.action = tccw_pkg::ACT_LOCATE;
         if ($urandom_range(99) < 80) begin
            r.x = 8'($urandom_range(GRID_COLS - 1));
            r.y = 8'($urandom_range(GRID_ROWS - 1));
         end
      end else if (p < 67) begin
         r.action = tccw_pkg::ACT_MOVE;
         if ($urandom_range(99) < 70) begin
            r.x = 8'($urandom_range(8)) - 8'd4;
            r.y = 8'($urandom_range(8)) - 8'd4;
         end
      end else if (p < 88) begin
         r.action = tccw_pkg::ACT_READ;
         if ($urandom_range(99) < 85) begin
            r.x = 8'($urandom_range(GRID_COLS - 1));
            r.y = 8'($urandom_range(GRID_ROWS - 1));
         end
      end else if (p < 91) begin
         r.action = tccw_pkg::ACT_SCROLL;
      end else if (p < 94) begin
         r.action = tccw_pkg::ACT_CLEAR;
      end else if (p < 97) begin
         r.action = ($urandom_range(1) == 0) ? ACT_SPARE_6 : ACT_SPARE_7;
      end
      return r;
   endfunction

   task automatic send_req(input console_req_type r, input logic typed,
                           input console_rsp_type want);
      console_rsp_type pred;
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, r.ccol, r.nrows, r.y, r.x, r.code};
      req_tuser  <= {r.wide, r.action};
      do @(posedge clock); while (!req_tready);
      predict_console_action(r, pred);
      action_count[r.action]++;
      if (pred.status == tccw_pkg::STAT_WIDTH) width_errors++;
      if (pred.status == tccw_pkg::STAT_OFFSCREEN) offscreen_count++;
      awaited_reports.push_back(typed ? want : pred);
   endtask

   task automatic wait_for_reports(int settle);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_config(logic [7:0] fg, logic [7:0] bg, logic wrap, logic uni);
      logic [1:0] idx [4];
      logic [7:0] val [4];
      idx = '{tccw_pkg::CFG_FG, tccw_pkg::CFG_BG, tccw_pkg::CFG_WRAP,
              tccw_pkg::CFG_UNICODE};
      val = '{fg, bg, {7'b0, wrap}, {7'b0, uni}};
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_fg      = fg;
      cfg_bg      = bg;
      cfg_wrap    = wrap;
      cfg_unicode = uni;
      settings_used++;
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      console_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_reports.size() == 0) begin
            note_failure($sformatf("unexpected beat: st=%0d col=%0d row=%0d data=%h",
                                   rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8],
                                   rsp_tdata[47:16]));
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[7:0] !== want.col ||
                rsp_tdata[15:8] !== want.row || rsp_tdata[31:16] !== want.code ||
                rsp_tdata[39:32] !== want.fg || rsp_tdata[47:40] !== want.bg) begin
               note_failure({
                  $sformatf("mismatch: expected st=%0d col=%0d row=%0d code=%h fg=%h bg=%h",
                            want.status, want.col, want.row, want.code, want.fg,
                            want.bg),
                  $sformatf(", got st=%0d col=%0d row=%0d code=%h fg=%h bg=%h",
                            rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8],
                            rsp_tdata[31:16], rsp_tdata[39:32], rsp_tdata[47:40])});
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d reports outstanding.",
                  cycle_count, awaited_reports.size());
         $display("FAIL text_console_cell_writer");
         $finish;
      end
   end

   initial begin
      console_req_type r;
      logic [7:0]      fg;
      logic [7:0]      bg;
      logic            wrap;
      logic            uni;
      int              n;

      for (int i = 0; i < GRID_CELLS; i++) begin
         shadow_cells[i] = blank_cell(tccw_pkg::RESET_BG);
      end
      for (int i = 0; i < 8; i++) begin
         action_count[i] = 0;
      end
      cur_col     = 0;
      cur_row     = 0;
      cfg_fg      = tccw_pkg::RESET_FG;
      cfg_bg      = tccw_pkg::RESET_BG;
      cfg_wrap    = 1'b1;
      cfg_unicode = 1'b0;

      directed_rows = '{
         '{req_of(tccw_pkg::ACT_READ, 16'h0000, 1'b0, 0, 0, 0, 0), 1'b1,
           '{tccw_pkg::STAT_OK, 8'd0, 8'd0, 16'h0000, 8'hFF, 8'h00}},
         '{req_of(tccw_pkg::ACT_READ, 16'hFFFF, 1'b1, -128, -128, 31, 255), 1'b1,
           '{tccw_pkg::STAT_OFFSCREEN, 8'd0, 8'd0, 16'h0000, 8'h00, 8'h00}},
         '{req_of(tccw_pkg::ACT_READ, 16'h0000, 1'b0, 127, 127, 0, 0), 1'b1,
           '{tccw_pkg::STAT_OFFSCREEN, 8'd0, 8'd0, 16'h0000, 8'h00, 8'h00}},
         '{req_of(tccw_pkg::ACT_READ, 16'h0000, 1'b0, 47, 23, 0, 0), 1'b1,
           '{tccw_pkg::STAT_OK, 8'd0, 8'd0, 16'h0000, 8'hFF, 8'h00}},
         '{req_of(tccw_pkg::ACT_PUT, 16'h0041, 1'b0, 0, 0, 0, 0), 1'b0, NO_RSP},
         '{req_of(tccw_pkg::ACT_PUT, 16'h01FF, 1'b0, 0, 0, 0, 0), 1'b0, NO_RSP},
         '{req_of(tccw_pkg::ACT_PUT, 16'hFFFF, 1'b1, 0, 0, 0, 0), 1'b1,
           '{tccw_pkg::STAT_WIDTH, 8'd2, 8'd0, 16'h0000, 8'h00, 8'h00}},
         '{req_of(tccw_pkg::ACT_PUT, tccw_pkg::CODE_NL, 1'b0, 0, 0, 0, 0), 1'b0, NO_RSP},
         '{req_of(tccw_pkg::ACT_PUT, tccw_pkg::CODE_TAB, 1'b0, 0, 0, 0, 0), 1'b0, NO_RSP},
         '{req_of(tccw_pkg::ACT_PUT, tccw_pkg::CODE_CR, 1'b1, 0, 0, 0, 0), 1'b0, NO_RSP},
         '{req_of(tccw_pkg::ACT_READ, 16'h0000, 1'b0, 0, 0, 0, 0), 1'b0, NO_RSP},
         '{req_of(tccw_pkg::ACT_READ, 16'h0000, 1'b0, 1, 0, 0, 0), 1'b0, NO_RSP},
         '{req_of(tccw_pkg::ACT_LOCATE, 16'h0000, 1'b0, 127, 127, 0, 0), 1'b1,
           '{tccw_pkg::STAT_OK, 8'd127, 8'd127, 16'h0000, 8'h00, 8'h00}},
         '{req_of(tccw_pkg::ACT_PUT, 16'h0042, 1'b0, 0, 0, 0, 0), 1'b0, NO_RSP},
         '{req_of(tccw_pkg::ACT_LOCATE, 16'h0000, 1'b0, -128, -128, 0, 0), 1'b1,
           '{tccw_pkg::STAT_OK, 8'd0, 8'd0, 16'h0000, 8'h00, 8'h00}},
         '{req_of(tccw_pkg::ACT_MOVE, 16'h0000, 1'b0, -128, -128, 0, 0), 1'b1,
           '{tccw_pkg::STAT_OK, 8'd0, 8'd0, 16'h0000, 8'h00, 8'h00}},
         '{req_of(tccw_pkg::ACT_MOVE, 16'h0000, 1'b0, 127, 127, 0, 0), 1'b1,
           '{tccw_pkg::STAT_OK, 8'd0, 8'd23, 16'h0000, 8'h00, 8'h00}},
         '{req_of(tccw_pkg::ACT_LOCATE, 16'h0000, 1'b0, 47, 23, 0, 0), 1'b1,
           '{tccw_pkg::STAT_OK, 8'd47, 8'd23, 16'h0000, 8'h00, 8'h00}},
         '{req_of(tccw_pkg::ACT_PUT, 16'h0043, 1'b0, 0, 0, 0, 0), 1'b0, NO_RSP},
         '{req_of(tccw_pkg::ACT_READ, 16'h0000, 1'b0, 47, 22, 0, 0), 1'b0, NO_RSP},
         '{req_of(tccw_pkg::ACT_SCROLL, 16'h0000, 1'b0, 0, 0, 0, 0), 1'b0, NO_RSP},
         '{req_of(tccw_pkg::ACT_SCROLL, 16'h0000, 1'b0, 0, 0, 31, 0), 1'b0, NO_RSP},
         '{req_of(tccw_pkg::ACT_CLEAR, 16'h0000, 1'b0, 0, 0, 0, 255), 1'b0, NO_RSP},
         '{req_of(tccw_pkg::ACT_READ, 16'h0000, 1'b0, 47, 23, 0, 0), 1'b0, NO_RSP},
         '{req_of(ACT_SPARE_6, 16'hFFFF, 1'b1, 127, -128, 31, 255), 1'b0, NO_RSP}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle = 32;
      recv_idle = 61;
      foreach (directed_rows[i]) begin
         send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end
      send_req(req_of(ACT_SPARE_7, 16'h0000, 1'b0, 0, 0, 0, 0), 1'b0, NO_RSP);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_for_reports(8);
         fg   = 8'($urandom_range(255));
         bg   = 8'($urandom_range(255));
         wrap = ($urandom_range(3) != 0);
         uni  = 1'($urandom_range(1));
         case (seg)
            0: begin
               fg = 8'h00; bg = 8'hFF; wrap = 1'b1; uni = 1'b0;
            end
            1: begin
               fg = 8'hFF; bg = 8'h00; wrap = 1'b1; uni = 1'b1;
            end
            2: begin
               wrap = 1'b0; uni = 1'b0;
            end
            3: begin
               wrap = 1'b0; uni = 1'b1;
            end
            default: begin
            end
         endcase
         if (seg == SAT_SEG) wrap = 1'b0;
         set_config(fg, bg, wrap, uni);

         if (seg < 6) begin
            send_idle = 32;
            recv_idle = 61;
         end else if (seg < 12) begin
            send_idle = 61;
            recv_idle = 32;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end

         if (seg == SAT_SEG) begin
            send_req(req_of(tccw_pkg::ACT_LOCATE, 16'h0000, 1'b0, 127, 127, 0, 0),
                     1'b0, NO_RSP);
            for (int i = 1; i < 300; i++) begin
               r = random_req((i < 100) ? STYLE_COL_RUN : STYLE_ROW_RUN);
               send_req(r, 1'b0, NO_RSP);
            end
         end else begin
            n = 100;
            for (int i = 0; i < n; i++) begin
               r = random_req(STYLE_MIXED);
               send_req(r, 1'b0, NO_RSP);
            end
         end
      end

      wait_for_reports(20);
      $display("Covered %0d puts, %0d locates, %0d moves, %0d scrolls, %0d clears,",
               action_count[tccw_pkg::ACT_PUT], action_count[tccw_pkg::ACT_LOCATE],
               action_count[tccw_pkg::ACT_MOVE], action_count[tccw_pkg::ACT_SCROLL],
               action_count[tccw_pkg::ACT_CLEAR]);
      $display("%0d reads and %0d spare actions; saw %0d width errors and %0d off-screen",
               action_count[tccw_pkg::ACT_READ],
               action_count[ACT_SPARE_6] + action_count[ACT_SPARE_7],
               width_errors, offscreen_count);
      $display("reports over %0d register settings; %0d mismatches.",
               settings_used, fail_count);
      if (fail_count == 0) begin
         $display("PASS text_console_cell_writer");
      end else begin
         $display("FAIL text_console_cell_writer");
      end
      $finish;
   end

endmodule
